### rtl/utf16_to_utf8_encoder_assert.svh
// assertion macros for the encoder checker
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define UTFENC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf16_to_utf8_encoder: assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define UTFENC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf16_to_utf8_encoder: assertion failed");

`endif

### rtl/utfenc_pkg.sv
// types and constants of the utf-16 to utf-8 encoder
`default_nettype none

package utfenc_pkg;

    // most bytes one code unit can cause: four for a pair plus the terminator
    localparam int MAX_BYTES   = 5;
    localparam int COUNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [15:0] HIGH_SURR_LO   = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI   = 16'hDBFF;

    // 0x10000 - 0xdc00, the fixed part of the pair code point
    localparam logic [20:0] PAIR_BIAS = 21'h10000 - 21'h0DC00;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // all bytes one code unit causes, first byte in slot 0
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
    } t_job;

endpackage

`default_nettype wire

### rtl/utfenc_queue.sv
// small register queue of byte jobs between the front and back parts
`default_nettype none

module utfenc_queue #(
    parameter int DEPTH = utfenc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  utfenc_pkg::t_job      i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output utfenc_pkg::t_job      o_data,
    input  wire logic             i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utfenc_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/utfenc_front.sv
// front part: accepts code units, pairs surrogates and builds byte jobs
`default_nettype none

module utfenc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  utfenc_pkg::t_in_item  i_in_data,
    output logic                  o_in_stall,
    output logic                  o_push,
    output utfenc_pkg::t_job      o_job,
    input  wire logic             i_full
);

    logic        r_pending;
    logic [9:0]  r_held;
    logic [15:0] unit;
    logic        fin;
    logic        is_high;
    logic        accept;
    logic [20:0] cp;
    utfenc_pkg::t_job job;

    assign unit    = i_in_data.code_unit;
    assign fin     = i_in_data.final_unit;
    assign is_high = (unit >= utfenc_pkg::HIGH_SURR_LO) && (unit <= utfenc_pkg::HIGH_SURR_HI);
    assign accept  = i_in_valid && !i_full;

    // low ten bits of the high surrogate are all that the pair needs
    assign cp = {1'b0, r_held, 10'b0} + utfenc_pkg::PAIR_BIAS + {5'b0, unit};

    always_comb begin
        job = '0;
        priority if (r_pending) begin
            job.bytes[0] = utfenc_pkg::LEAD4 | {5'b0, cp[20:18]};
            job.bytes[1] = utfenc_pkg::CONT  | {2'b0, cp[17:12]};
            job.bytes[2] = utfenc_pkg::CONT  | {2'b0, cp[11:6]};
            job.bytes[3] = utfenc_pkg::CONT  | {2'b0, cp[5:0]};
            job.count    = utfenc_pkg::COUNT_W'(4);
        end else if (unit < utfenc_pkg::ONE_BYTE_LIMIT) begin
            job.bytes[0] = unit[7:0];
            job.count    = utfenc_pkg::COUNT_W'(1);
        end else if (unit < utfenc_pkg::TWO_BYTE_LIMIT) begin
            job.bytes[0] = utfenc_pkg::LEAD2 | {3'b0, unit[10:6]};
            job.bytes[1] = utfenc_pkg::CONT  | {2'b0, unit[5:0]};
            job.count    = utfenc_pkg::COUNT_W'(2);
        end else if (!is_high) begin
            job.bytes[0] = utfenc_pkg::LEAD3 | {4'b0, unit[15:12]};
            job.bytes[1] = utfenc_pkg::CONT  | {2'b0, unit[11:6]};
            job.bytes[2] = utfenc_pkg::CONT  | {2'b0, unit[5:0]};
            job.count    = utfenc_pkg::COUNT_W'(3);
        end else begin
            job.count    = '0;
        end
        // terminator slot is already zero
        if (fin) begin
            job.count = job.count + 1'b1;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = accept && (job.count != '0);
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= !r_pending && is_high && !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_pending && is_high) begin
            r_held <= unit[9:0];
        end
    end

endmodule

`default_nettype wire

### rtl/utfenc_back.sv
// back part: walks the head job and sends one byte per cycle while a job waits and the output is not stalled
`default_nettype none

module utfenc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  utfenc_pkg::t_job      i_job,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output utfenc_pkg::t_out_item o_out_data,
    input  wire logic             i_out_stall
);

    logic                         r_out_valid;
    utfenc_pkg::t_out_item        r_out_data;
    logic [utfenc_pkg::IDX_W-1:0] r_idx;
    logic                         advance;
    logic                         last;

    assign advance = !r_out_valid || !i_out_stall;
    assign last    = (utfenc_pkg::COUNT_W'(r_idx) == i_job.count - 1'b1);
    assign o_pop   = advance && i_valid && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (advance) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_out_data.out_byte    <= i_job.bytes[r_idx];
            r_out_data.last_of_run <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_encoder.sv
// utf-16 to utf-8 encoder: jobs are queued, then sent from the output byte register
// throughput: one byte per cycle at the output while a job waits and the output is not
//   stalled, from the single output byte register; a held high surrogate yields no byte
// input side takes a new unit every cycle while the job queue has room
// reset is synchronous, active low: clears the held surrogate, the queue and output valid
`default_nettype none

module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = utfenc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input transaction: one utf-16 code unit
    input  wire logic             i_in_valid,
    input  utfenc_pkg::t_in_item  i_in_data,
    output logic                  o_in_stall,
    // output transaction: one utf-8 byte
    output logic                  o_out_valid,
    output utfenc_pkg::t_out_item o_out_data,
    input  wire logic             i_out_stall
);

    // front to queue
    logic             push;
    utfenc_pkg::t_job push_job;
    logic             full;

    // queue to back
    logic             head_valid;
    utfenc_pkg::t_job head_job;
    logic             pop;

    // front: classifies the unit, pairs surrogates, and builds the whole
    // byte list (with the terminator on a final unit) combinationally
    utfenc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    // jobs wait here so the front keeps taking units while bytes drain
    utfenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_job),
        .i_pop   (pop)
    );

    // back: serializes the head job into the output register, marking the
    // last byte, and pops the job on that byte
    utfenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

### rtl/utfenc_checker.sv
// port-level checker for the encoder and its bind
`default_nettype none

`include "utf16_to_utf8_encoder_assert.svh"

module utfenc_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input utfenc_pkg::t_in_item  i_in_data,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input utfenc_pkg::t_out_item o_out_data,
    input wire logic             i_out_stall
);

    logic out_take;
    logic lead_byte;

    assign out_take  = o_out_valid && !i_out_stall;
    assign lead_byte = (o_out_data.out_byte[7:6] == 2'b11);

    // a stalled input transaction holds
    `UTFENC_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_data))

    // a stalled output transaction holds
    `UTFENC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // bytes of one run are offered with no gap between them
    `UTFENC_ASSERT_NEXT(a_run_gapless, out_take && !o_out_data.last_of_run, o_out_valid)

    // a lead byte is never the end of a run and a continuation byte follows it
    `UTFENC_ASSERT_SAME(a_lead_not_last, o_out_valid && lead_byte, !o_out_data.last_of_run)
    `UTFENC_ASSERT_NEXT(a_lead_then_cont, out_take && lead_byte, o_out_data.out_byte[7:6] == 2'b10)

endmodule

bind utf16_to_utf8_encoder utfenc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

### verif/utf16_to_utf8_encoder_tb.sv
// testbench for the utf-16 to utf-8 encoder: directed cases and random stall traffic against a byte-level predictor
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOW_LIMIT   = 10;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    utfenc_pkg::t_in_item  in_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    utfenc_pkg::t_out_item out_data;
    logic                  out_stall = 1'b0;

    // predictor state: a high surrogate waiting for its partner
    logic        surr_held  = 1'b0;
    logic [15:0] surr_value = '0;

    // utf-8 bytes the encoder still owes, oldest first
    utfenc_pkg::t_out_item utf8_bytes_due[$];

    int  units_sent   = 0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    // random idle bursts on the sending and receiving side
    bit  in_idle_on   = 1'b1;
    bit  out_idle_on  = 1'b1;

    utf16_to_utf8_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // append one byte to the list of bytes due
    function automatic void owe_byte(logic [7:0] b);
        utfenc_pkg::t_out_item item;
        item.out_byte    = b;
        item.last_of_run = 1'b0;
        utf8_bytes_due = {utf8_bytes_due, item};
    endfunction

    // works out the bytes one accepted code unit causes and queues them
    function automatic void encode_unit(logic [15:0] cu, logic is_last);
        int          before_n;
        logic [31:0] cp;
        before_n = utf8_bytes_due.size();
        if (surr_held) begin
            // partner is taken whatever its value, so the code point can exceed 0x10ffff
            cp = ((32'(surr_value) - 32'hD800) << 10) + 32'h10000 + 32'(cu) - 32'hDC00;
            owe_byte(utfenc_pkg::LEAD4 | 8'(cp >> 18));
            owe_byte(utfenc_pkg::CONT | 8'((cp >> 12) & 32'h3F));
            owe_byte(utfenc_pkg::CONT | 8'((cp >> 6) & 32'h3F));
            owe_byte(utfenc_pkg::CONT | 8'(cp & 32'h3F));
            surr_held  = 1'b0;
            surr_value = '0;
        end else if (cu < utfenc_pkg::ONE_BYTE_LIMIT) begin
            owe_byte(cu[7:0]);
        end else if (cu < utfenc_pkg::TWO_BYTE_LIMIT) begin
            owe_byte(utfenc_pkg::LEAD2 | 8'(cu >> 6));
            owe_byte(utfenc_pkg::CONT | {2'b00, cu[5:0]});
        end else if (cu < utfenc_pkg::HIGH_SURR_LO || cu > utfenc_pkg::HIGH_SURR_HI) begin
            // stray low surrogates land here too
            owe_byte(utfenc_pkg::LEAD3 | 8'(cu >> 12));
            owe_byte(utfenc_pkg::CONT | {2'b00, cu[11:6]});
            owe_byte(utfenc_pkg::CONT | {2'b00, cu[5:0]});
        end else if (!is_last) begin
            surr_held  = 1'b1;
            surr_value = cu;
        end
        // a final unit adds the terminator; a high surrogate flagged final is dropped
        if (is_last) begin
            owe_byte(8'h00);
            surr_held  = 1'b0;
            surr_value = '0;
        end
        if (utf8_bytes_due.size() > before_n)
            utf8_bytes_due[utf8_bytes_due.size()-1].last_of_run = 1'b1;
    endfunction

    // one input transaction, with an optional idle burst in front of it
    task automatic send_unit(input logic [15:0] cu, input logic is_last);
        int gap;
        @(negedge i_clk);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid             <= 1'b1;
        in_data.code_unit    <= cu;
        in_data.final_unit   <= is_last;
        do @(posedge i_clk); while (in_stall);
        encode_unit(cu, is_last);
        units_sent++;
    endtask

    function automatic logic [15:0] pick_three_byte_unit();
        logic [15:0] v;
        do v = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (v >= utfenc_pkg::HIGH_SURR_LO && v <= utfenc_pkg::HIGH_SURR_HI);
        return v;
    endfunction

    // one string with random content; pairs sometimes get a bad partner, and a high surrogate may end it
    task automatic send_text_string(input int max_len);
        int          len;
        int          kind;
        bit          is_last;
        logic [15:0] partner;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            is_last = (i == len - 1);
            kind    = $urandom_range(0, 9);
            if (kind <= 2) begin
                send_unit(16'($urandom_range(0, 16'h007F)), is_last);
            end else if (kind <= 4) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), is_last);
            end else if (kind <= 6) begin
                send_unit(pick_three_byte_unit(), is_last);
            end else if (is_last && $urandom_range(0, 7) == 0) begin
                // high surrogate that ends the string
                send_unit(16'($urandom_range(utfenc_pkg::HIGH_SURR_LO,
                                             utfenc_pkg::HIGH_SURR_HI)), 1'b1);
            end else begin
                send_unit(16'($urandom_range(utfenc_pkg::HIGH_SURR_LO,
                                             utfenc_pkg::HIGH_SURR_HI)), 1'b0);
                if ($urandom_range(0, 19) < 17)
                    partner = 16'($urandom_range(16'hDC00, 16'hDFFF));
                else
                    partner = 16'($urandom);
                send_unit(partner, is_last);
            end
        end
    endtask

    task automatic test_directed();
        // boundaries of each byte length, stray lows, both ends of the surrogate range
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // proper pairs at both corners
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // partner that is no low surrogate: lowest and highest code unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // high surrogate as partner of a high surrogate
        send_unit(16'hDA12, 1'b0);
        send_unit(16'hDB00, 1'b0);
        // high surrogate flagged final: terminator only
        send_unit(16'hD801, 1'b1);
        // pair completed by a final unit: four bytes plus terminator
        send_unit(16'hD9AB, 1'b0);
        send_unit(16'hDE01, 1'b1);
        send_unit(16'h0041, 1'b1);
        send_unit(16'h07FF, 1'b1);
    endtask

    task automatic test_random_text(input int target);
        while (units_sent < target) begin
            // some strings run with no idling at all
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            send_text_string(12);
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_random_noise(input int target);
        while (units_sent < target)
            send_unit(16'($urandom), ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_full_rate(input int target);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        while (units_sent < target)
            send_text_string(8);
    endtask

    // receiving side: random stall bursts, changed at the falling edge
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (!out_idle_on)
                burst = 0;
            if (burst == 0 && out_idle_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 11);
            if (burst > 0) begin
                out_stall <= 1'b1;
                burst--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // compare every accepted output transaction with the oldest byte due
    always @(posedge i_clk) begin
        utfenc_pkg::t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (utf8_bytes_due.size() == 0) begin
                if (fail_count < SHOW_LIMIT)
                    $display("unexpected byte %02h last %0b with nothing due",
                             out_data.out_byte, out_data.last_of_run);
                fail_count++;
            end else begin
                want = utf8_bytes_due.pop_front();
                if (want.out_byte !== out_data.out_byte ||
                    want.last_of_run !== out_data.last_of_run) begin
                    if (fail_count < SHOW_LIMIT)
                        $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                                 want.out_byte, out_data.out_byte,
                                 want.last_of_run, out_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_text(300);
        test_random_noise(400);
        test_full_rate(470);

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (utf8_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && utf8_bytes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/utfenc_pkg.sv
rtl/utfenc_queue.sv
rtl/utfenc_front.sv
rtl/utfenc_back.sv
rtl/utf16_to_utf8_encoder.sv
rtl/utfenc_checker.sv
verif/utf16_to_utf8_encoder_tb.sv
